FILE: rtl/pcc_pkg.sv
// pcc_pkg: shared types and constants for the pearson correlation block
// no dependencies; imported by the ctrl, datapath and top-level rtl modules of the block
`default_nettype none
package pcc_pkg;

  // op codes carried in tuser of the input channel
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int ONE_Q14   = 16384;
  localparam int MUL_SHIFT = 15;
  localparam int CORR_BITS = 16;
  localparam int SRCH_BITS = 15;
  localparam int COL_BITS  = 4;
  localparam int ROW_BITS  = 8;
  localparam int RC_BITS   = 9;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MLOAD,
    S_MRUN,
    S_MSTORE,
    S_NEXT,
    S_PREP,
    S_FINISH
  } state_t;

  // products worked out by the serial multiplier, in order
  typedef enum logic [3:0] {
    ST_NSXX,
    ST_SXSQ,
    ST_NSYY,
    ST_SYSQ,
    ST_NSXY,
    ST_SXSY,
    ST_LHS,
    ST_DEN,
    ST_SRCH
  } step_t;

  typedef struct packed {
    logic  start;
    logic  rd;
    logic  mul_load;
    logic  mul_store;
    logic  prep;
    logic  res_load;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic last_row;
    logic pipe_busy;
    logic mul_busy;
    logic var_zero;
    logic search_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/pcc_store.sv
// pcc_store: one column store, single write port and registered read port
// uses no package items
`default_nettype none
module pcc_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  parameter int AW    = 12
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic signed [WIDTH-1:0]      rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/pcc_datapath.sv
// pcc_datapath: row accumulation, shared shift-add multiplier, root-free search
// depends on pcc_pkg (cmd_t, sts_t, step codes, constants)
`default_nettype none
module pcc_datapath #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int LR          = 9,
  parameter int AW          = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pcc_pkg::cmd_t                 cmd,
  output pcc_pkg::sts_t                      sts,
  input  wire logic [LR-1:0]                 n,
  input  wire logic [pcc_pkg::COL_BITS-1:0]  q_col,
  input  wire logic [pcc_pkg::COL_BITS-1:0]  q_partner,
  output logic [AW-1:0]                      rd_addr_a,
  output logic [AW-1:0]                      rd_addr_b,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_data_a,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_data_b,
  output logic signed [pcc_pkg::CORR_BITS-1:0] corr,
  output logic                               zv
);
  import pcc_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int SW  = SB + LR;
  localparam int PRW = 2 * SB + LR;
  localparam int VW  = 2 * LR + 2 * SB;
  localparam int PW  = 2 * VW + 32;

  logic [COL_BITS-1:0] col_a, col_b;
  logic                ok_a, ok_b;
  logic [LR-1:0]       k;
  logic                v1, v2;
  logic signed [2*SB-1:0] pxy, pxx, pyy;
  logic signed [SW-1:0]   sx, sy;
  logic signed [PRW-1:0]  sxy;
  logic [PRW-1:0]         sxx, syy;
  logic signed [SB-1:0]   xs, ys;
  logic signed [SB-1:0]   xs_d, ys_d;

  logic [PW-1:0] ma, mb, macc, tmp, mag, lhs, den;
  logic [PW-1:0] sel_a, sel_b;
  logic [VW-1:0] vx, vy;
  logic          neg;
  logic [SRCH_BITS-1:0]   lo, hi, mid, mid_c;
  logic [2*SRCH_BITS-1:0] odd2;
  logic [SRCH_BITS-1:0]   odd_c;

  logic [SW-1:0]  sx_mag, sy_mag;
  logic [PRW-1:0] sxy_mag;
  logic signed [PW:0] t1s, t2s, dnum, dabs;

  assign rd_addr_a = AW'(32'(col_a) * MAX_ROWS + 32'(k));
  assign rd_addr_b = AW'(32'(col_b) * MAX_ROWS + 32'(k));

  // an out-of-range column reads as zeros
  assign xs = ok_a ? rd_data_a : '0;
  assign ys = ok_b ? rd_data_b : '0;

  assign sx_mag  = sx[SW-1] ? SW'(-sx) : SW'(sx);
  assign sy_mag  = sy[SW-1] ? SW'(-sy) : SW'(sy);
  assign sxy_mag = sxy[PRW-1] ? PRW'(-sxy) : PRW'(sxy);

  // row walk: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_a <= q_col;
      col_b <= q_partner;
      ok_a  <= 32'(q_col) < MAX_COLS;
      ok_b  <= 32'(q_partner) < MAX_COLS;
      k     <= '0;
      sx    <= '0;
      sy    <= '0;
      sxy   <= '0;
      sxx   <= '0;
      syy   <= '0;
    end else begin
      if (cmd.rd) begin
        k <= k + LR'(1);
      end
      if (v2) begin
        sx  <= sx + SW'(xs_d);
        sy  <= sy + SW'(ys_d);
        sxy <= sxy + PRW'(pxy);
        sxx <= sxx + PRW'($unsigned(pxx));
        syy <= syy + PRW'($unsigned(pyy));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      xs_d <= xs;
      ys_d <= ys;
      pxy  <= xs * ys;
      pxx  <= xs * xs;
      pyy  <= ys * ys;
    end
  end

  // operand choice for each product
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    case (cmd.step)
      ST_NSXX: begin sel_a = PW'(sxx);     sel_b = PW'(n);      end
      ST_SXSQ: begin sel_a = PW'(sx_mag);  sel_b = PW'(sx_mag); end
      ST_NSYY: begin sel_a = PW'(syy);     sel_b = PW'(n);      end
      ST_SYSQ: begin sel_a = PW'(sy_mag);  sel_b = PW'(sy_mag); end
      ST_NSXY: begin sel_a = PW'(sxy_mag); sel_b = PW'(n);      end
      ST_SXSY: begin sel_a = PW'(sx_mag);  sel_b = PW'(sy_mag); end
      ST_LHS:  begin sel_a = mag;          sel_b = mag;         end
      ST_DEN:  begin sel_a = PW'(vx);      sel_b = PW'(vy);     end
      ST_SRCH: begin sel_a = den;          sel_b = PW'(odd2);   end
      default: begin sel_a = '0;           sel_b = '0;          end
    endcase
  end

  // shift-add multiplier, one multiplier bit per cycle, stops when mb runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      mb <= '0;
    end else if (cmd.mul_load) begin
      mb <= sel_b;
    end else if (mb != '0) begin
      mb <= mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma   <= sel_a;
      macc <= '0;
    end else if (mb != '0) begin
      ma <= ma << 1;
      if (mb[0]) begin
        macc <= macc + ma;
      end
    end
  end

  // numerator n*sxy - sx*sy as a signed difference
  always_comb begin
    t1s = $signed({1'b0, tmp});
    t2s = $signed({1'b0, macc});
    if (sxy[PRW-1]) begin
      t1s = -t1s;
    end
    if (sx[SW-1] ^ sy[SW-1]) begin
      t2s = -t2s;
    end
    dnum = t1s - t2s;
    dabs = dnum[PW] ? -dnum : dnum;
  end

  assign mid_c = SRCH_BITS'((32'(lo) + 32'(hi) + 32'd1) >> 1);
  assign odd_c = SRCH_BITS'(2 * 32'(mid_c) - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (cmd.mul_store) begin
      case (cmd.step)
        ST_DEN: begin
          lo <= '0;
          hi <= SRCH_BITS'(ONE_Q14);
        end
        ST_SRCH: begin
          // largest m with (2m-1)^2 * den <= lhs
          if (macc <= lhs) begin
            lo <= mid;
          end else begin
            hi <= mid - SRCH_BITS'(1);
          end
        end
        default: begin
          lo <= lo;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.step)
        ST_NSXX, ST_NSYY, ST_NSXY: tmp <= macc;
        ST_SXSQ: vx <= VW'(tmp - macc);
        ST_SYSQ: vy <= VW'(tmp - macc);
        ST_SXSY: begin
          neg <= dnum[PW];
          mag <= dabs[PW-1:0] << MUL_SHIFT;
        end
        ST_LHS:  lhs <= macc;
        ST_DEN:  den <= macc;
        default: tmp <= tmp;
      endcase
    end
    if (cmd.prep) begin
      mid  <= mid_c;
      odd2 <= odd_c * odd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      zv <= sts.var_zero;
      if (sts.var_zero) begin
        corr <= '0;
      end else if (neg) begin
        corr <= -$signed(CORR_BITS'(lo));
      end else begin
        corr <= $signed(CORR_BITS'(lo));
      end
    end
  end

  assign sts.last_row    = (k == LR'(n - LR'(1)));
  assign sts.pipe_busy   = v1 | v2;
  assign sts.mul_busy    = (mb != '0);
  assign sts.var_zero    = (vx == '0) || (vy == '0);
  assign sts.search_done = (lo >= hi);

  a_search_order: assert property (@(posedge clk) disable iff (rst) lo <= hi)
    else $error("search bounds crossed");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (!zv || corr == '0))
    else $error("zero variance with nonzero result");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (corr <= 16'sd16384 && corr >= -16'sd16384))
    else $error("result out of range");

endmodule
`default_nettype wire

FILE: rtl/pcc_ctrl.sv
// pcc_ctrl: sequencer for one query (row walk, product steps, search, result)
// depends on pcc_pkg (state_t, step_t, cmd_t, sts_t, op codes)
`default_nettype none
module pcc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic [1:0]    op,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output pcc_pkg::cmd_t      cmd,
  input  wire pcc_pkg::sts_t sts
);
  import pcc_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= ST_NSXX;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (s_tvalid && op == OP_QUERY) begin
          state_next = S_READ;
          step_next  = ST_NSXX;
        end
      end
      S_READ:   if (sts.last_row) state_next = S_DRAIN;
      S_DRAIN:  if (!sts.pipe_busy) state_next = S_MLOAD;
      S_MLOAD:  state_next = S_MRUN;
      S_MRUN:   if (!sts.mul_busy) state_next = S_MSTORE;
      S_MSTORE: state_next = S_NEXT;
      S_NEXT: begin
        case (step)
          ST_SYSQ: begin
            if (sts.var_zero) begin
              state_next = S_FINISH;
            end else begin
              state_next = S_MLOAD;
              step_next  = ST_NSXY;
            end
          end
          ST_DEN, ST_SRCH: begin
            state_next = S_PREP;
            step_next  = ST_SRCH;
          end
          default: begin
            state_next = S_MLOAD;
            step_next  = step_t'(step + 4'd1);
          end
        endcase
      end
      S_PREP:   state_next = sts.search_done ? S_FINISH : S_MLOAD;
      S_FINISH: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = step;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid && op == OP_QUERY;
      end
      S_READ:   cmd.rd = 1'b1;
      S_MLOAD:  cmd.mul_load = 1'b1;
      S_MSTORE: cmd.mul_store = 1'b1;
      S_PREP:   cmd.prep = !sts.search_done;
      S_FINISH: cmd.res_load = !m_tvalid || m_tready;
      default:  cmd.step = step;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRUN && !sts.mul_busy) |=> state == S_MSTORE)
    else $error("multiply did not complete");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: rtl/pearson_correlation_pairs.sv
// pearson_correlation_pairs: top level, two column stores, controller, datapath
// depends on pcc_pkg, pcc_store, pcc_ctrl, pcc_datapath
//
// channel  dir  handshake              content
// s_       in   s_tvalid / s_tready    tuser: op; tdata: column, row, sample, partner
// m_       out  m_tvalid / m_tready    tuser: zero_variance; tdata: correlation
// cfg_     in   cfg_valid / cfg_ready  row_count (always ready)
//
// a query first walks the n rows of the column pair, then works out
// eight products on one shift-add multiplier (one multiplier bit per cycle) and
// up to 15 search products on the same multiplier
// rst is synchronous and clears control state and row_count (to 2); the stores hold anything
// a finished result waits in the output register while new items are taken
`default_nettype none
module pearson_correlation_pairs #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // column[3:0] row[11:4] sample[27:12] partner[31:28]
  input  wire logic [1:0]  s_tuser,  // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // correlation
  output logic             m_tuser,  // zero_variance
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [pcc_pkg::RC_BITS-1:0] cfg_data
);
  import pcc_pkg::*;

  localparam int LR    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [RC_BITS-1:0] row_count;
  logic [LR-1:0]      n;
  cmd_t cmd;
  sts_t sts;

  logic [COL_BITS-1:0] col, partner;
  logic [ROW_BITS-1:0] row;
  logic [15:0]         sample;
  logic signed [SAMPLE_BITS-1:0] wsample;
  logic          ld_ok, we_a, we_b, accept;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic signed [SAMPLE_BITS-1:0] rdata_a, rdata_b;
  logic signed [CORR_BITS-1:0]   corr;

  assign col     = s_tdata[3:0];
  assign row     = s_tdata[11:4];
  assign sample  = s_tdata[27:12];
  assign partner = s_tdata[31:28];

  generate
    if (SAMPLE_BITS <= 16) begin : g_narrow
      assign wsample = sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
      // the sign bit lies above the field, so the value stays positive
      assign wsample = $signed(SAMPLE_BITS'(sample));
    end
  endgenerate

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= RC_BITS'(2);
    end else if (cfg_valid) begin
      row_count <= cfg_data;
    end
  end

  always_comb begin
    if (row_count < RC_BITS'(2)) begin
      n = LR'(2);
    end else if (32'(row_count) > MAX_ROWS) begin
      n = LR'(MAX_ROWS);
    end else begin
      n = LR'(row_count);
    end
  end

  assign accept = s_tvalid && s_tready;
  assign ld_ok  = (32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);
  assign we_a   = accept && ld_ok && s_tuser == OP_LOAD_A;
  assign we_b   = accept && ld_ok && s_tuser == OP_LOAD_B;
  assign waddr  = AW'(32'(col) * MAX_ROWS + 32'(row));

  pcc_store #(.DEPTH(DEPTH), .WIDTH(SAMPLE_BITS), .AW(AW)) u_store_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wsample),
    .raddr(raddr_a), .rdata(rdata_a)
  );

  pcc_store #(.DEPTH(DEPTH), .WIDTH(SAMPLE_BITS), .AW(AW)) u_store_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wsample),
    .raddr(raddr_b), .rdata(rdata_b)
  );

  pcc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .op(s_tuser), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  pcc_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS),
    .LR(LR), .AW(AW)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .n(n),
    .q_col(col), .q_partner(partner),
    .rd_addr_a(raddr_a), .rd_addr_b(raddr_b),
    .rd_data_a(rdata_a), .rd_data_b(rdata_b),
    .corr(corr), .zv(m_tuser)
  );

  assign m_tdata = corr;

endmodule
`default_nettype wire
